// ----- hdl/dse_pkg.sv -----
// Shared types and constants of the descriptive statistics engine.
// Used by dse_cell, dse_chain and descriptive_statistics_engine.
package dse_pkg;

    localparam int DATA_W  = 32;
    localparam int TOTAL_W = 40;
    localparam int COUNT_W = 9;
    localparam int RANK_W  = 7;

    localparam logic [RANK_W-1:0] RANK_FULL  = 7'd100;
    localparam logic [RANK_W-1:0] RANK_RESET = 7'd50;

    // Register index as decoded from paddr bit 2.
    localparam logic REG_PERCENTILE = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last;
    } in_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        sample_count;
        logic signed [TOTAL_W-1:0] total;
        logic signed [DATA_W-1:0]  average;
        logic signed [DATA_W-1:0]  middle_value;
        logic signed [DATA_W-1:0]  most_frequent;
        logic signed [DATA_W-1:0]  smallest;
        logic signed [DATA_W-1:0]  largest;
        logic [DATA_W-1:0]         spread;
        logic                      spread_invalid;
        logic signed [DATA_W-1:0]  rank_value;
    } out_req_t;

    // Broadcast control for every cell of the sorting chain.
    typedef struct packed {
        logic                     ins;
        logic                     shift;
        logic signed [DATA_W-1:0] x;
    } cell_ctrl_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [DATA_W-1:0] value;
    } cell_link_t;

endpackage

// ----- hdl/dse_cell.sv -----
// One cell of the sorting chain: holds one sample and its valid bit.
// Depends on dse_pkg.
module dse_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  dse_pkg::cell_ctrl_t ctrl,
    input  dse_pkg::cell_link_t left,
    input  dse_pkg::cell_link_t right,
    output dse_pkg::cell_link_t link
);

    logic                               valid_reg;
    logic signed [dse_pkg::DATA_W-1:0]  value_reg;
    logic                               gt;

    // An empty cell counts as larger than any new sample.
    assign gt = !valid_reg || (value_reg > ctrl.x);

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            value_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= right.valid;
            value_reg <= right.value;
        end
        else if (ctrl.ins)
        begin
            valid_reg <= valid_reg | left.valid;
            if (left.gt)
            begin
                value_reg <= left.value;
            end
            else if (gt)
            begin
                value_reg <= ctrl.x;
            end
        end
    end

endmodule

// ----- hdl/dse_chain.sv -----
// Row of sorting cells that keeps the loaded samples in ascending order.
// Depends on dse_pkg and dse_cell.
module dse_chain
#(
    parameter int DEPTH = 256
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dse_pkg::cell_ctrl_t                ctrl,
    output logic signed [dse_pkg::DATA_W-1:0]  head
);

    dse_pkg::cell_link_t link_w [DEPTH];
    dse_pkg::cell_link_t head_link;
    dse_pkg::cell_link_t tail_link;

    // Left of the first cell stands a valid entry that is never larger.
    assign head_link.valid = 1'b1;
    assign head_link.gt    = 1'b0;
    assign head_link.value = '0;
    assign tail_link.valid = 1'b0;
    assign tail_link.gt    = 1'b1;
    assign tail_link.value = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dse_pkg::cell_link_t left_w;
        dse_pkg::cell_link_t right_w;

        if (i == 0)
        begin : g_first
            assign left_w = head_link;
        end
        else
        begin : g_mid_l
            assign left_w = link_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = tail_link;
        end
        else
        begin : g_mid_r
            assign right_w = link_w[i+1];
        end

        dse_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .link  (link_w[i])
        );
    end

    assign head = link_w[0].value;

endmodule

// ----- hdl/dse_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Standalone; used by descriptive_statistics_engine.
module dse_div
#(
    parameter int XW = 82,
    parameter int DW = 18
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [XW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [XW-1:0] quotient,
    output logic          done
);

    localparam int CNT_W = $clog2(XW + 1);

    logic [XW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      rem_sh;
    logic             fits;
    logic [DW-1:0]    rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[XW-1]};
        fits     = rem_sh >= {1'b0, div_reg};
        rem_next = fits ? DW'(rem_sh - {1'b0, div_reg}) : DW'(rem_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= CNT_W'(XW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[XW-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign done      = done_reg;

endmodule

// ----- hdl/descriptive_statistics_engine.sv -----
// Descriptive statistics engine: sorting cell chain plus a result sequencer.
// Depends on dse_pkg, dse_chain (dse_cell) and dse_div.
//
// Usage: samples arrive on the in_* channel, one request per cycle while the
// block is loading; a request is taken at a clock edge with in_valid high and
// in_stall low. Each sample drops into a chain of MAX_SAMPLES cells that keeps
// the set sorted; samples beyond MAX_SAMPLES are dropped. A request marked
// last ends the set and starts the result pass, during which in_stall is high.
// The pass shifts the chain out once, one sample a cycle, runs the shared
// one-bit-a-cycle divider twice (mean and variance), two shift-add products
// and a 32-step square root; the split of the percentile position by 100 uses
// short reciprocal multiplications. Internal widths are XW = 64 + 2*CW and
// SW = 32 + CW, where CW = clog2(MAX_SAMPLES+1).
// Loading runs at one sample per cycle; the result pass sets the set rate.
// One result request leaves on out_* and is held in an output register while
// out_stall is high; the next set may load meanwhile, but its result waits.
// Reset empties the set and sets percentile_point to 50. The APB port holds
// percentile_point at byte address 0 and should be written only while idle.
module descriptive_statistics_engine
#(
    parameter int MAX_SAMPLES = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dse_pkg::in_req_t  in_req,
    output logic              out_valid,
    input  logic              out_stall,
    output dse_pkg::out_req_t out_req,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Count, sum, square-sum, product and divisor widths.
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = 32 + CW;
    localparam int QW  = 63 + CW;
    localparam int XW  = 64 + 2 * CW;
    localparam int DW  = (2 * CW > 7) ? 2 * CW : 7;
    localparam int PW  = 7 + CW;
    localparam int ITW = $clog2(XW + 1);

    // ceil(2^31 / 100); exact quotient by 100 for any 24-bit operand.
    localparam logic [24:0] RECIP_100 = 25'd21474837;

    typedef enum logic [4:0] {
        S_LOAD, S_POS, S_POSW, S_POSF, S_STREAM, S_DRAIN, S_NQLD, S_NQ, S_TTLD,
        S_TT, S_AVG, S_AVGW, S_VAR, S_VARW, S_SQRT, S_FRAC, S_FRACA, S_FRACB,
        S_FRACW, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           n_reg;
    logic signed [SW-1:0]    total_reg;
    logic [QW-1:0]           q_reg;
    logic [63:0]             sq_reg;
    logic                    sq_v_reg;
    logic [CW-1:0]           k_reg;
    logic signed [31:0]      prev_reg;
    logic [CW-1:0]           run_reg;
    logic [CW-1:0]           best_reg;
    logic signed [31:0]      mode_reg;
    logic signed [31:0]      min_reg;
    logic signed [31:0]      max_reg;
    logic signed [31:0]      med_a_reg;
    logic signed [31:0]      med_b_reg;
    logic [PW-1:0]           pos_reg;
    logic [CW-1:0]           pe_reg;
    logic [CW-1:0]           pe1_reg;
    logic [6:0]              f_reg;
    logic signed [31:0]      base_reg;
    logic signed [31:0]      upper_reg;
    logic [22:0]             fa_reg;
    logic [22:0]             fl_reg;
    logic [15:0]             qa_reg;
    logic [23:0]             lo_reg;
    logic [XW-1:0]           x_reg;
    logic [XW-1:0]           sa_a_reg;
    logic [SW-1:0]           sa_b_reg;
    logic [ITW-1:0]          cnt_reg;
    logic signed [31:0]      avg_reg;
    logic [63:0]             rad_reg;
    logic [33:0]             rem_reg;
    logic [31:0]             root_reg;
    logic                    sat_reg;
    logic signed [31:0]      rv_reg;
    logic [2*CW-1:0]         den_reg;
    logic [6:0]              point_reg;
    logic                    div_start_reg;
    logic [XW-1:0]           div_a_reg;
    logic [DW-1:0]           div_b_reg;
    logic                    out_valid_reg;
    dse_pkg::out_req_t       out_reg;

    logic                    accept;
    logic                    room;
    dse_pkg::cell_ctrl_t     ctrl;
    logic signed [31:0]      head;
    logic [XW-1:0]           div_quo;
    logic                    div_done;
    logic [6:0]              rank;
    logic [SW-1:0]           tmag;
    logic [31:0]             hmag;
    logic [63:0]             sq_full;
    logic [CW-1:0]           run_new;
    logic [CW-1:0]           mid_a;
    logic [CW-1:0]           mid_b;
    logic [CW:0]             e_plus;
    logic [35:0]             rt_sh;
    logic [35:0]             rt_trial;
    logic [31:0]             diff;
    logic [6:0]              ra_w;
    logic signed [32:0]      med_sum;
    logic signed [32:0]      med_half;
    logic                    cfg_wr;

    // Quotient by 100 through a multiply by the scaled reciprocal.
    function automatic logic [23:0] div100(input logic [23:0] v);
        logic [48:0] prod;
        prod = 49'(v) * 49'(RECIP_100);
        return 24'(prod >> 31);
    endfunction

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == dse_pkg::REG_PERCENTILE);
    assign prdata = (paddr[2] == dse_pkg::REG_PERCENTILE) ? {25'd0, point_reg} : 32'd0;
    assign rank   = (point_reg > dse_pkg::RANK_FULL) ? dse_pkg::RANK_FULL : point_reg;

    // ------------------------------------------------------------------
    // Sorting chain: inserts while loading, shifts toward the head while
    // the result pass streams the sorted set.
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != S_LOAD);
    assign accept   = in_valid && !in_stall;
    assign room     = n_reg < CW'(MAX_SAMPLES);

    assign ctrl.ins   = accept && room;
    assign ctrl.shift = (state_reg == S_STREAM);
    assign ctrl.x     = in_req.sample;

    dse_chain #(.DEPTH(MAX_SAMPLES)) u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .head  (head)
    );

    dse_div #(.XW(XW), .DW(DW)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .quotient  (div_quo),
        .done      (div_done)
    );

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------
    always_comb
    begin
        tmag     = total_reg[SW-1] ? SW'(-total_reg) : SW'(total_reg);
        hmag     = head[31] ? 32'(-head) : 32'(head);
        sq_full  = 64'(hmag) * 64'(hmag);
        // A new run starts at the head of the stream or on a value change.
        run_new  = ((k_reg == '0) || (head != prev_reg)) ? CW'(1) : run_reg + CW'(1);
        mid_b    = n_reg >> 1;
        mid_a    = n_reg[0] ? (n_reg >> 1) : (n_reg >> 1) - CW'(1);
        e_plus   = {1'b0, pe_reg} + (CW+1)'(1);
        rt_sh    = {rem_reg, rad_reg[63:62]};
        rt_trial = {2'b00, root_reg, 2'b01};
        // The set is sorted, so the gap to the upper neighbor is never negative.
        diff     = upper_reg - base_reg;
        // Remainder of the high partial product after the split by 100.
        ra_w     = 7'(fa_reg - 23'(qa_reg) * 23'(dse_pkg::RANK_FULL));
        // Median of an even set truncates toward zero.
        med_sum  = 33'(med_a_reg) + 33'(med_b_reg);
        med_half = (med_sum + 33'(med_sum[32])) >>> 1;
    end

    // ------------------------------------------------------------------
    // Sequencer and result registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            n_reg         <= '0;
            total_reg     <= '0;
            q_reg         <= '0;
            sq_reg        <= '0;
            sq_v_reg      <= 1'b0;
            k_reg         <= '0;
            prev_reg      <= '0;
            run_reg       <= '0;
            best_reg      <= '0;
            mode_reg      <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            med_a_reg     <= '0;
            med_b_reg     <= '0;
            pos_reg       <= '0;
            pe_reg        <= '0;
            pe1_reg       <= '0;
            f_reg         <= '0;
            base_reg      <= '0;
            upper_reg     <= '0;
            fa_reg        <= '0;
            fl_reg        <= '0;
            qa_reg        <= '0;
            lo_reg        <= '0;
            x_reg         <= '0;
            sa_a_reg      <= '0;
            sa_b_reg      <= '0;
            cnt_reg       <= '0;
            avg_reg       <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            sat_reg       <= 1'b0;
            rv_reg        <= '0;
            den_reg       <= '0;
            point_reg     <= dse_pkg::RANK_RESET;
            div_start_reg <= 1'b0;
            div_a_reg     <= '0;
            div_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                point_reg <= pwdata[6:0];
            end

            // Square-sum accumulator: each square is registered, then added in the next cycle.
            sq_reg   <= sq_full;
            sq_v_reg <= (state_reg == S_STREAM);
            if (sq_v_reg)
            begin
                q_reg <= q_reg + QW'(sq_reg);
            end

            // The divider start pulse is registered alongside its operands, so both reach it together.
            div_start_reg <= (state_reg == S_AVG) || (state_reg == S_VAR);

            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            n_reg     <= n_reg + CW'(1);
                            total_reg <= total_reg + SW'(in_req.sample);
                        end
                        if (in_req.last)
                        begin
                            state_reg <= S_POS;
                        end
                    end
                end

                S_POS:
                begin
                    pos_reg   <= PW'(rank) * PW'(n_reg - CW'(1));
                    den_reg   <= (2*CW)'(n_reg) * (2*CW)'(n_reg - CW'(1));
                    q_reg     <= '0;
                    k_reg     <= '0;
                    run_reg   <= '0;
                    best_reg  <= '0;
                    state_reg <= S_POSW;
                end

                // Whole part of the percentile position.
                S_POSW:
                begin
                    pe_reg    <= CW'(div100(24'(pos_reg)));
                    state_reg <= S_POSF;
                end

                // Fractional part, and the upper neighbor clamped to the set.
                S_POSF:
                begin
                    f_reg     <= 7'(pos_reg - PW'(pe_reg) * PW'(dse_pkg::RANK_FULL));
                    pe1_reg   <= (e_plus < {1'b0, n_reg}) ? CW'(e_plus) : pe_reg;
                    state_reg <= S_STREAM;
                end

                S_STREAM:
                begin
                    k_reg    <= k_reg + CW'(1);
                    prev_reg <= head;
                    run_reg  <= run_new;
                    if (run_new > best_reg)
                    begin
                        best_reg <= run_new;
                        mode_reg <= head;
                    end
                    if (k_reg == '0)
                    begin
                        min_reg <= head;
                    end
                    if (k_reg == mid_a)
                    begin
                        med_a_reg <= head;
                    end
                    if (k_reg == mid_b)
                    begin
                        med_b_reg <= head;
                    end
                    if (k_reg == pe_reg)
                    begin
                        base_reg <= head;
                    end
                    if (k_reg == pe1_reg)
                    begin
                        upper_reg <= head;
                    end
                    if (k_reg == n_reg - CW'(1))
                    begin
                        max_reg   <= head;
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN:
                begin
                    state_reg <= S_NQLD;
                end

                S_NQLD:
                begin
                    sa_a_reg  <= XW'(q_reg);
                    sa_b_reg  <= SW'(n_reg);
                    x_reg     <= '0;
                    cnt_reg   <= ITW'(SW);
                    state_reg <= S_NQ;
                end

                // x = n * sum of squares, one multiplier bit per cycle.
                S_NQ:
                begin
                    if (sa_b_reg[0])
                    begin
                        x_reg <= x_reg + sa_a_reg;
                    end
                    sa_a_reg <= sa_a_reg << 1;
                    sa_b_reg <= sa_b_reg >> 1;
                    cnt_reg  <= cnt_reg - ITW'(1);
                    if (cnt_reg == ITW'(1))
                    begin
                        state_reg <= S_TTLD;
                    end
                end

                S_TTLD:
                begin
                    sa_a_reg  <= XW'(tmag);
                    sa_b_reg  <= tmag;
                    cnt_reg   <= ITW'(SW);
                    state_reg <= S_TT;
                end

                // x -= total squared, leaving n*n*(n-1) times the variance / n.
                S_TT:
                begin
                    if (sa_b_reg[0])
                    begin
                        x_reg <= x_reg - sa_a_reg;
                    end
                    sa_a_reg <= sa_a_reg << 1;
                    sa_b_reg <= sa_b_reg >> 1;
                    cnt_reg  <= cnt_reg - ITW'(1);
                    if (cnt_reg == ITW'(1))
                    begin
                        state_reg <= S_AVG;
                    end
                end

                S_AVG:
                begin
                    div_a_reg <= XW'(tmag);
                    div_b_reg <= DW'(n_reg);
                    state_reg <= S_AVGW;
                end

                S_AVGW:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= total_reg[SW-1] ? -32'(div_quo) : 32'(div_quo);
                        state_reg <= S_VAR;
                    end
                end

                S_VAR:
                begin
                    div_a_reg <= x_reg;
                    div_b_reg <= DW'(den_reg);
                    state_reg <= S_VARW;
                end

                S_VARW:
                begin
                    if (div_done)
                    begin
                        sat_reg   <= |div_quo[XW-1:64];
                        rad_reg   <= div_quo[63:0];
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= ITW'(32);
                        state_reg <= S_SQRT;
                    end
                end

                // Digit-by-digit square root, one result bit per cycle.
                S_SQRT:
                begin
                    rad_reg <= rad_reg << 2;
                    if (rt_sh >= rt_trial)
                    begin
                        rem_reg  <= 34'(rt_sh - rt_trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= 34'(rt_sh);
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - ITW'(1);
                    if (cnt_reg == ITW'(1))
                    begin
                        state_reg <= S_FRAC;
                    end
                end

                // The interpolation step f*diff/100 is split at bit 16 of diff
                // so that each quotient by 100 works on 24 bits at most.
                S_FRAC:
                begin
                    fa_reg    <= 23'(f_reg) * 23'(diff[31:16]);
                    fl_reg    <= 23'(f_reg) * 23'(diff[15:0]);
                    state_reg <= S_FRACA;
                end

                S_FRACA:
                begin
                    qa_reg    <= 16'(div100(24'(fa_reg)));
                    state_reg <= S_FRACB;
                end

                S_FRACB:
                begin
                    lo_reg    <= {1'b0, ra_w, 16'h0000} + 24'(fl_reg);
                    state_reg <= S_FRACW;
                end

                S_FRACW:
                begin
                    rv_reg    <= base_reg + 32'({qa_reg, 16'h0000}) + 32'(div100(lo_reg));
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_reg.sample_count         <= 9'(n_reg);
                        out_reg.total                <= 40'(total_reg);
                        out_reg.average              <= avg_reg;
                        out_reg.middle_value         <= n_reg[0] ? med_b_reg : 32'(med_half);
                        out_reg.most_frequent        <= mode_reg;
                        out_reg.smallest             <= min_reg;
                        out_reg.largest              <= max_reg;
                        out_reg.spread_invalid       <= (n_reg == CW'(1));
                        out_reg.rank_value           <= rv_reg;
                        if (n_reg == CW'(1))
                        begin
                            out_reg.spread <= '0;
                        end
                        else if (sat_reg)
                        begin
                            out_reg.spread <= '1;
                        end
                        else
                        begin
                            out_reg.spread <= root_reg;
                        end
                        n_reg     <= '0;
                        total_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for descriptive_statistics_engine: a directed table
// followed by random sample sets, checked against a behavioral predictor.
// Depends on dse_pkg and the engine RTL.
module testbench;

    localparam int SET_CAP   = 256;
    localparam int ITEM_GOAL = 1250;
    localparam int DRAIN_CYC = 900;   // a full set plus the result pass, with margin

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    dse_pkg::in_req_t  in_req = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    dse_pkg::out_req_t out_req;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor state: the set kept in ascending order, its exact sum, and
    // the percentile rank as last written.
    logic signed [31:0] set_sorted[$];
    longint             set_sum;
    logic [6:0]         rank_pct;

    // Statistics results still owed by the engine, oldest first.
    dse_pkg::out_req_t stats_due[$];
    int       fail_count = 0;
    int       items_sent = 0;
    bit       no_idle = 1'b0;      // turns off random idling on both sides
    bit       hold_request = 1'b0; // asks the receiver for one long hold-off

    descriptive_statistics_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
        .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    // Loads one sample into the predicted set (beyond SET_CAP it is dropped) and works out
    // the statistics of the set so far; on a last sample the caller queues them and clears the set.
    function automatic dse_pkg::out_req_t stats_of_set(logic signed [31:0] s);
        dse_pkg::out_req_t r;
        int            n, k, run, best, e, f, pos;
        longint        dev, base, diff;
        logic [127:0]  mag, acc, den, var_q, c;
        logic [63:0]   root;
        if (set_sorted.size() < SET_CAP)
        begin
            pos = set_sorted.size();
            while (pos > 0 && set_sorted[pos-1] > s)
                pos--;
            set_sorted.insert(pos, s);
            set_sum += longint'(s);
        end
        n = set_sorted.size();
        r = '0;
        r.sample_count = n[8:0];
        r.total = set_sum[39:0];
        r.average = 32'(set_sum / n);
        if (n % 2 == 0)
            r.middle_value = 32'((longint'(set_sorted[n/2-1]) + set_sorted[n/2]) / 2);
        else
            r.middle_value = set_sorted[n/2];
        // Mode: runs in the sorted set, the first longest run wins.
        best = 0;
        k = 0;
        while (k < n)
        begin
            run = 1;
            while (k + run < n && set_sorted[k+run] == set_sorted[k])
                run++;
            if (run > best)
            begin
                best = run;
                r.most_frequent = set_sorted[k];
            end
            k += run;
        end
        r.smallest = set_sorted[0];
        r.largest = set_sorted[n-1];
        if (n == 1)
            r.spread_invalid = 1'b1;
        else
        begin
            // Sum of (n*s - sum)^2 over n^2 (n-1) is the variance in LSB^2.
            acc = '0;
            for (k = 0; k < n; k++)
            begin
                dev = longint'(n) * set_sorted[k] - set_sum;
                mag = (dev < 0) ? 128'(-dev) : 128'(dev);
                acc += mag * mag;
            end
            den = 128'(n) * 128'(n) * 128'(n - 1);
            var_q = acc / den;
            root = '0;
            for (k = 63; k >= 0; k--)
            begin
                c = 128'(root | (64'd1 << k));
                if (c * c <= var_q)
                    root = c[63:0];
            end
            r.spread = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
        end
        // Ranks above 100 percent act as 100.
        k = (rank_pct > dse_pkg::RANK_FULL) ? int'(dse_pkg::RANK_FULL) : int'(rank_pct);
        e = k * (n - 1) / 100;
        f = k * (n - 1) % 100;
        if (f == 0 || e + 1 >= n)
            r.rank_value = set_sorted[e];
        else
        begin
            base = set_sorted[e];
            diff = longint'(set_sorted[e+1]) - base;
            r.rank_value = 32'(base + (longint'(f) * diff) / 100);
        end
        return r;
    endfunction

    task automatic note_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: mismatch in %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Sends one request and waits until the engine takes it. Stall is sampled
    // at the falling edge, so the decision never races the rising edge.
    task automatic send_sample(logic signed [31:0] s, bit last, bit typed,
                               dse_pkg::out_req_t want);
        dse_pkg::out_req_t calc;
        while (!no_idle && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= '{sample: s, last: last};
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        calc = stats_of_set(s);
        if (last)
        begin
            stats_due.insert(stats_due.size(), typed ? want : calc);
            set_sorted.delete();
            set_sum = 0;
        end
        items_sent++;
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // APB write of percentile_point, then a read back of the same register.
    task automatic set_rank(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'({dse_pkg::REG_PERCENTILE, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rank_pct = value[6:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        note_field("percentile_point readback", 64'(rank_pct), 64'(prdata[6:0]));
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // A mix of full-range values, small values, Q16.16 values, a small pool
    // that makes ties likely, and the two extremes.
    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2, 3:    return 32'($signed($urandom_range(0, 2000)) - 1000);
            4, 5:    return 32'(($signed($urandom_range(0, 200)) - 100) <<< 16);
            6, 7:    return 32'($urandom_range(0, 5) * 32'h0001_8000);
            8:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
        endcase
    endfunction

    typedef struct {
        logic signed [31:0] sample;
        bit                 last;
        bit                 typed;
        dse_pkg::out_req_t  want;
    } stim_row_t;

    // Single-sample sets at the extremes and at zero have results that can be read off
    // directly; longer sets go through the predictor.
    stim_row_t directed[] = '{
        '{32'sh7FFF_FFFF, 1, 1, '{9'd1, 40'sh00_7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h0, 1'b1, 32'sh7FFF_FFFF}},
        '{32'sh8000_0000, 1, 1, '{9'd1, 40'shFF_8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'h0, 1'b1, 32'sh8000_0000}},
        '{32'sh0, 1, 1, '{9'd1, 40'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
            32'h0, 1'b1, 32'sh0}},
        '{32'sh8000_0000, 0, 0, '0},
        '{32'sh7FFF_FFFF, 0, 0, '0},
        '{32'sh8000_0000, 1, 0, '0},
        '{32'sh5, 0, 0, '0},
        '{32'sh3, 0, 0, '0},
        '{32'sh5, 0, 0, '0},
        '{32'sh3, 0, 0, '0},
        '{32'sh1, 1, 0, '0},
        '{32'sh000A_0000, 0, 0, '0},
        '{-32'sh0007_0000, 0, 0, '0},
        '{32'sh0004_0000, 0, 0, '0},
        '{32'sh0004_0000, 1, 0, '0},
        '{-32'sh1, 0, 0, '0},
        '{32'sh1, 1, 0, '0}
    };

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                for (held = 0; held < 2500; held++)
                    @(posedge clk);
            end
            out_stall <= (!no_idle && $urandom_range(0, 99) < 26);
        end
    end

    // Result checker: a result is taken at the rising edge that follows a
    // falling edge with out_valid high and out_stall low.
    initial
    begin
        dse_pkg::out_req_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (stats_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %h", $time, out_req);
                end
                else
                begin
                    want = stats_due.pop_front();
                    note_field("sample_count", 64'(want.sample_count), 64'(out_req.sample_count));
                    note_field("total", 64'(want.total), 64'(out_req.total));
                    note_field("average", 64'(want.average), 64'(out_req.average));
                    note_field("middle_value", 64'(want.middle_value),
                               64'(out_req.middle_value));
                    note_field("most_frequent", 64'(want.most_frequent),
                               64'(out_req.most_frequent));
                    note_field("smallest", 64'(want.smallest), 64'(out_req.smallest));
                    note_field("largest", 64'(want.largest), 64'(out_req.largest));
                    note_field("spread", 64'(want.spread), 64'(out_req.spread));
                    note_field("spread_invalid", 64'(want.spread_invalid),
                               64'(out_req.spread_invalid));
                    note_field("rank_value", 64'(want.rank_value), 64'(out_req.rank_value));
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random sets in phases with
    // different percentile settings.
    initial
    begin
        int               row, size, k, phase;
        logic [31:0]      ranks[] = '{0, 100, 127, 1, 99, 37};
        set_sum = 0;
        rank_pct = dse_pkg::RANK_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (row = 0; row < directed.size(); row++)
            send_sample(directed[row].sample, directed[row].last,
                        directed[row].typed, directed[row].want);
        wait_for_results();

        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            // Every 150 items: drain, then move to a new rank.
            if (items_sent >= 150 * (phase + 1))
            begin
                wait_for_results();
                set_rank(phase < ranks.size() ? ranks[phase] : 32'($urandom_range(0, 127)));
                phase++;
            end
            no_idle = (items_sent > 500 && items_sent < 650);
            if (items_sent > 800 && items_sent < 820)
                hold_request = 1'b1;
            // Mostly short sets; a few fill the store, some overrun it.
            k = $urandom_range(0, 99);
            if (k < 2)
                size = SET_CAP;
            else if (k < 4)
                size = $urandom_range(SET_CAP + 1, SET_CAP + 40);
            else
                size = $urandom_range(1, 12);
            for (row = 0; row < size; row++)
                send_sample(pick_sample(), row == size - 1, 1'b0, '0);
        end
        wait_for_results();
        repeat (DRAIN_CYC) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #(12 * 5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
